FILE: hdl/tridiagonal_coarse_stencil_defines.svh
// Assertion macros shared by the tridiagonal coarse stencil RTL.
`ifndef TRIDIAGONAL_COARSE_STENCIL_DEFINES_SVH
`define TRIDIAGONAL_COARSE_STENCIL_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tridiagonal coarse stencil check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tridiagonal coarse stencil check failed");

`endif

FILE: hdl/tcs_pkg.sv
// Package with the shared constants of the tridiagonal coarse stencil.
package tcs_pkg;
   localparam int COEF_WIDTH_DEFAULT = 32;
   localparam int NUM_TERMS = 4;
   localparam int TERM_WL = 0;
   localparam int TERM_EL = 1;
   localparam int TERM_WR = 2;
   localparam int TERM_ER = 3;
endpackage

FILE: hdl/tridiagonal_coarse_stencil.sv
// Top level of the tridiagonal coarse stencil: a fully pipelined Galerkin row reduction.
//
// The req channel carries one item per row: the west, diagonal and east
// coefficients of the left, middle and right fine rows, all signed fixed point.
// The rsp channel returns the coarse west, diagonal and east coefficients of the
// middle row with a divide fault flag and a saturation flag.
// The csr port writes the symmetric mode bit; it is sampled with each item.
// Each item goes through one multiply stage, 2*COEF_WIDTH restoring divide
// stages that each retire one quotient bit of four dividers in parallel, and
// three stages for sign, sum and saturation.
// One item is accepted every cycle while the output is not stalled.
// The whole pipeline advances together; while rsp_valid is high and rsp_ready is
// low every stage holds and req_ready is low, so nothing is lost or repeated.
// Reset clears all stage valid bits and the symmetric mode bit.
// A zero left or right diagonal gives zero results with the divide fault set.
module tridiagonal_coarse_stencil #(
   parameter int COEF_WIDTH = tcs_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COEF_WIDTH-1:0] req_left_west,
   input  logic signed [COEF_WIDTH-1:0] req_left_diag,
   input  logic signed [COEF_WIDTH-1:0] req_left_east,
   input  logic signed [COEF_WIDTH-1:0] req_mid_west,
   input  logic signed [COEF_WIDTH-1:0] req_mid_diag,
   input  logic signed [COEF_WIDTH-1:0] req_mid_east,
   input  logic signed [COEF_WIDTH-1:0] req_right_west,
   input  logic signed [COEF_WIDTH-1:0] req_right_diag,
   input  logic signed [COEF_WIDTH-1:0] req_right_east,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COEF_WIDTH-1:0] rsp_coarse_west,
   output logic signed [COEF_WIDTH-1:0] rsp_coarse_diag,
   output logic signed [COEF_WIDTH-1:0] rsp_coarse_east,
   output logic                         rsp_divide_fault,
   output logic                         rsp_saturated
);
   `include "tridiagonal_coarse_stencil_defines.svh"

   localparam int W  = COEF_WIDTH;
   localparam int NW = 2 * COEF_WIDTH;
   localparam int NT = tcs_pkg::NUM_TERMS;
   localparam int SW = NW + 3;

   typedef struct packed {
      logic                 fault;
      logic                 sym;
      logic [NT-1:0]        neg;
      logic signed [W-1:0]  diag;
      logic [W-1:0]         dl;
      logic [W-1:0]         dr;
   } side_type;

   logic adv;
   logic sym_ff, sym_in;

   logic                 vld_ff  [0:NW];
   side_type             side_ff [0:NW];
   logic [NT-1:0][NW-1:0] dq_ff  [0:NW];
   logic [NT-1:0][W-1:0]  rem_ff [0:NW];

   logic [W-1:0] m_lw, m_ld, m_le, m_mw, m_me, m_rw, m_rd, m_re;
   side_type side_in;
   logic [NT-1:0][NW-1:0] prod_in;

   logic                      n_vld_ff;
   logic                      n_fault_ff, n_sym_ff;
   logic signed [W-1:0]       n_diag_ff;
   logic signed [NW:0]        n_q_ff [NT];
   logic signed [NW:0]        n_q_in [NT];

   logic                      s_vld_ff;
   logic                      s_fault_ff, s_sym_ff;
   logic signed [SW-1:0]      s_west_ff, s_diag_ff, s_east_ff;
   logic signed [SW-1:0]      s_west_in, s_diag_in, s_east_in;

   logic                      o_vld_ff;
   logic signed [W-1:0]       o_west_ff, o_diag_ff, o_east_ff;
   logic                      o_fault_ff, o_sat_ff, o_sym_ff;
   logic signed [W-1:0]       o_west_in, o_diag_in, o_east_in;
   logic                      o_sat_in;
   logic                      clip_w, clip_d, clip_e;
   logic signed [SW-1:0]      sat_max, sat_min;

   assign adv       = !o_vld_ff || rsp_ready;
   assign req_ready = adv;

   assign sym_in = csr_wr_en ? csr_wr_data : sym_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b0;
      end else begin
         sym_ff <= sym_in;
      end
   end

   always_comb begin
      m_lw = req_left_west[W-1]  ? W'(-req_left_west)  : W'(req_left_west);
      m_ld = req_left_diag[W-1]  ? W'(-req_left_diag)  : W'(req_left_diag);
      m_le = req_left_east[W-1]  ? W'(-req_left_east)  : W'(req_left_east);
      m_mw = req_mid_west[W-1]   ? W'(-req_mid_west)   : W'(req_mid_west);
      m_me = req_mid_east[W-1]   ? W'(-req_mid_east)   : W'(req_mid_east);
      m_rw = req_right_west[W-1] ? W'(-req_right_west) : W'(req_right_west);
      m_rd = req_right_diag[W-1] ? W'(-req_right_diag) : W'(req_right_diag);
      m_re = req_right_east[W-1] ? W'(-req_right_east) : W'(req_right_east);
      prod_in[tcs_pkg::TERM_WL] = NW'(m_mw) * NW'(m_lw);
      prod_in[tcs_pkg::TERM_EL] = NW'(m_mw) * NW'(m_le);
      prod_in[tcs_pkg::TERM_WR] = NW'(m_me) * NW'(m_rw);
      prod_in[tcs_pkg::TERM_ER] = NW'(m_me) * NW'(m_re);
      side_in.fault = (req_left_diag == '0) || (req_right_diag == '0);
      side_in.sym   = sym_ff;
      side_in.neg[tcs_pkg::TERM_WL] =
         req_mid_west[W-1] ^ req_left_west[W-1] ^ req_left_diag[W-1];
      side_in.neg[tcs_pkg::TERM_EL] =
         req_mid_west[W-1] ^ req_left_east[W-1] ^ req_left_diag[W-1];
      side_in.neg[tcs_pkg::TERM_WR] =
         req_mid_east[W-1] ^ req_right_west[W-1] ^ req_right_diag[W-1];
      side_in.neg[tcs_pkg::TERM_ER] =
         req_mid_east[W-1] ^ req_right_east[W-1] ^ req_right_diag[W-1];
      side_in.diag = req_mid_diag;
      side_in.dl   = m_ld;
      side_in.dr   = m_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         dq_ff[0]   <= prod_in;
         rem_ff[0]  <= '0;
      end
   end

   for (genvar s = 0; s < NW; s++) begin : g_div
      logic [W:0]            part  [NT];
      logic [W:0]            trial [NT];
      logic [NT-1:0][NW-1:0] dq_in;
      logic [NT-1:0][W-1:0]  rem_in;

      always_comb begin
         for (int t = 0; t < NT; t++) begin
            part[t]  = {rem_ff[s][t], dq_ff[s][t][NW-1]};
            trial[t] = part[t] - {1'b0, (t < 2) ? side_ff[s].dl : side_ff[s].dr};
            dq_in[t] = {dq_ff[s][t][NW-2:0], !trial[t][W]};
            rem_in[t] = trial[t][W] ? part[t][W-1:0] : trial[t][W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s+1] <= side_ff[s];
            dq_ff[s+1]   <= dq_in;
            rem_ff[s+1]  <= rem_in;
         end
      end
   end

   always_comb begin
      for (int t = 0; t < NT; t++) begin
         n_q_in[t] = side_ff[NW].neg[t] ? -$signed({1'b0, dq_ff[NW][t]})
                                        :  $signed({1'b0, dq_ff[NW][t]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         n_vld_ff <= vld_ff[NW];
         s_vld_ff <= n_vld_ff;
         o_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_fault_ff <= side_ff[NW].fault;
         n_sym_ff   <= side_ff[NW].sym;
         n_diag_ff  <= side_ff[NW].diag;
         for (int t = 0; t < NT; t++) begin
            n_q_ff[t] <= n_q_in[t];
         end
      end
   end

   always_comb begin
      s_west_in = -SW'(n_q_ff[tcs_pkg::TERM_WL]);
      s_east_in = -SW'(n_q_ff[tcs_pkg::TERM_ER]);
      s_diag_in = SW'(n_diag_ff) - SW'(n_q_ff[tcs_pkg::TERM_EL])
                - SW'(n_q_ff[tcs_pkg::TERM_WR]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_fault_ff <= n_fault_ff;
         s_sym_ff   <= n_sym_ff;
         s_west_ff  <= s_west_in;
         s_diag_ff  <= s_diag_in;
         s_east_ff  <= s_east_in;
      end
   end

   assign sat_max = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
   assign sat_min = ~sat_max;

   always_comb begin
      clip_w = (s_west_ff > sat_max) || (s_west_ff < sat_min);
      clip_d = (s_diag_ff > sat_max) || (s_diag_ff < sat_min);
      clip_e = !s_sym_ff && ((s_east_ff > sat_max) || (s_east_ff < sat_min));
      o_west_in = (s_west_ff > sat_max) ? W'(sat_max) :
                  (s_west_ff < sat_min) ? W'(sat_min) : W'(s_west_ff);
      o_diag_in = (s_diag_ff > sat_max) ? W'(sat_max) :
                  (s_diag_ff < sat_min) ? W'(sat_min) : W'(s_diag_ff);
      o_east_in = (s_east_ff > sat_max) ? W'(sat_max) :
                  (s_east_ff < sat_min) ? W'(sat_min) : W'(s_east_ff);
      o_sat_in  = clip_w || clip_d || clip_e;
      if (s_sym_ff) begin
         o_east_in = '0;
      end
      if (s_fault_ff) begin
         o_west_in = '0;
         o_diag_in = '0;
         o_east_in = '0;
         o_sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_west_ff  <= o_west_in;
         o_diag_ff  <= o_diag_in;
         o_east_ff  <= o_east_in;
         o_fault_ff <= s_fault_ff;
         o_sat_ff   <= o_sat_in;
         o_sym_ff   <= s_sym_ff;
      end
   end

   assign rsp_valid        = o_vld_ff;
   assign rsp_coarse_west  = o_west_ff;
   assign rsp_coarse_diag  = o_diag_ff;
   assign rsp_coarse_east  = o_east_ff;
   assign rsp_divide_fault = o_fault_ff;
   assign rsp_saturated    = o_sat_ff;

   `TCS_ASSERT_SAME(a_fault_zero, rsp_valid && rsp_divide_fault,
      rsp_coarse_west == '0 && rsp_coarse_diag == '0 && rsp_coarse_east == '0 && !rsp_saturated)
   `TCS_ASSERT_SAME(a_sym_east_zero, rsp_valid && o_sym_ff, rsp_coarse_east == '0)
   `TCS_ASSERT_SAME(a_ready_follows_out, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   `TCS_ASSERT_NEXT(a_fault_capture, req_valid && req_ready && req_left_diag == '0,
      vld_ff[0] && side_ff[0].fault)
endmodule

FILE: tb/sv/tb_tridiagonal_coarse_stencil.sv
// Testbench for the tridiagonal coarse stencil: random and corner rows against a built-in predictor.
module tb_tridiagonal_coarse_stencil;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = tcs_pkg::COEF_WIDTH_DEFAULT;
   localparam int LATENCY = 2 * CW + 3;

   typedef logic signed [CW-1:0] coef_type;

   typedef struct packed {
      coef_type lw, ld, le, mw, md, me, rw, rd, re;
   } row_type;

   typedef struct packed {
      coef_type west, diag, east;
      logic     fault, sat;
   } stencil_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en = 1'b0;
   logic     csr_wr_data = 1'b0;
   logic     req_valid = 1'b0;
   logic     req_ready;
   row_type  req_row = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   coef_type rsp_coarse_west, rsp_coarse_diag, rsp_coarse_east;
   logic     rsp_divide_fault, rsp_saturated;

   logic        symmetric = 1'b0;
   stencil_type expected_stencils[$];
   int          mismatches = 0;

   tridiagonal_coarse_stencil #(.COEF_WIDTH(CW)) uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_west(req_row.lw), .req_left_diag(req_row.ld), .req_left_east(req_row.le),
      .req_mid_west(req_row.mw), .req_mid_diag(req_row.md), .req_mid_east(req_row.me),
      .req_right_west(req_row.rw), .req_right_diag(req_row.rd),
      .req_right_east(req_row.re),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_coarse_west(rsp_coarse_west), .rsp_coarse_diag(rsp_coarse_diag),
      .rsp_coarse_east(rsp_coarse_east), .rsp_divide_fault(rsp_divide_fault),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL tridiagonal_coarse_stencil");
      $finish;
   end

   function automatic logic signed [127:0] ratio(coef_type a, coef_type b, coef_type d);
      logic signed [127:0] p;
      p = 128'(signed'(a)) * 128'(signed'(b));
      return p / 128'(signed'(d));
   endfunction

   function automatic coef_type clip(logic signed [127:0] x, inout logic sat);
      logic signed [127:0] hi, lo;
      hi = 128'(signed'({1'b0, {(CW-1){1'b1}}}));
      lo = 128'(signed'({1'b1, {(CW-1){1'b0}}}));
      if (x > hi) begin
         sat = 1'b1;
         return hi[CW-1:0];
      end
      if (x < lo) begin
         sat = 1'b1;
         return lo[CW-1:0];
      end
      return x[CW-1:0];
   endfunction

   function automatic stencil_type coarsen(row_type r, logic sym);
      stencil_type s;
      logic        sat;
      s = '0;
      sat = 1'b0;
      if (r.ld == 0 || r.rd == 0) begin
         s.fault = 1'b1;
         return s;
      end
      s.west = clip(-ratio(r.mw, r.lw, r.ld), sat);
      s.diag = clip(128'(signed'(r.md)) - ratio(r.mw, r.le, r.ld)
                    - ratio(r.me, r.rw, r.rd), sat);
      s.east = sym ? coef_type'(0) : clip(-ratio(r.me, r.re, r.rd), sat);
      s.sat = sat;
      return s;
   endfunction

   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic coef_type any_coef();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(CW-1){1'b0}}};
         1: return {1'b0, {(CW-1){1'b1}}};
         2: return coef_type'($urandom_range(0, 4)) - 2;
         3: return coef_type'(signed'($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic row_type random_row(int bool_zero_ok);
      row_type r;
      r = {any_coef(), any_coef(), any_coef(), any_coef(), any_coef(),
           any_coef(), any_coef(), any_coef(), any_coef()};
      if (bool_zero_ok == 0) begin
         if (r.ld == 0) r.ld = 1;
         if (r.rd == 0) r.rd = -1;
      end
      return r;
   endfunction

   task automatic send_row(row_type r);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_stencils.push_back(coarsen(r, symmetric));
      req_valid <= 1'b1;
      req_row <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_and_write(logic sym);
      req_valid <= 1'b0;
      while (expected_stencils.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sym;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      symmetric = sym;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ready && gap_length() != 0) rsp_ready <= 1'b0;
         else if (!rsp_ready) rsp_ready <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      stencil_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stencils.size() == 0) begin
            $error("unexpected item: west %0d", rsp_coarse_west);
            mismatches++;
         end else begin
            e = expected_stencils.pop_front();
            if (rsp_coarse_west !== e.west) begin
               $error("coarse_west exp %0d got %0d", e.west, rsp_coarse_west);
               mismatches++;
            end
            if (rsp_coarse_diag !== e.diag) begin
               $error("coarse_diag exp %0d got %0d", e.diag, rsp_coarse_diag);
               mismatches++;
            end
            if (rsp_coarse_east !== e.east) begin
               $error("coarse_east exp %0d got %0d", e.east, rsp_coarse_east);
               mismatches++;
            end
            if (rsp_divide_fault !== e.fault) begin
               $error("divide_fault exp %0b got %0b", e.fault, rsp_divide_fault);
               mismatches++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   task automatic test_corners();
      coef_type mn, mx;
      mn = {1'b1, {(CW-1){1'b0}}};
      mx = {1'b0, {(CW-1){1'b1}}};
      send_row('{default: coef_type'(32'h1_0000)});
      send_row('{default: mx});
      send_row('{default: mn});
      send_row('{lw: mn, ld: 1, le: mn, mw: mn, md: mx, me: mn, rw: mx, rd: -1, re: mx});
      send_row('{lw: mx, ld: -1, le: mx, mw: mx, md: mn, me: mx, rw: mn, rd: 1, re: mn});
      send_row('{lw: 5, ld: 0, le: 7, mw: 9, md: 3, me: 2, rw: 1, rd: 4, re: 8});
      send_row('{lw: 5, ld: 4, le: 7, mw: 9, md: 3, me: 2, rw: 1, rd: 0, re: 8});
      send_row('{default: coef_type'(0)});
      send_row('{lw: -7, ld: 2, le: 7, mw: 3, md: -1, me: -3, rw: 7, rd: -2, re: -7});
      send_row('{lw: 0, ld: mn, le: 1, mw: 1, md: 0, me: 1, rw: 1, rd: mx, re: 0});
      send_row('{lw: mn, ld: 1, le: 0, mw: -1, md: 0, me: 0, rw: 0, rd: 1, re: 0});
      send_row('{default: coef_type'(-1)});
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_row(random_row(($urandom_range(0, 9) == 0) ? 1 : 0));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random(400);
      drain_and_write(1'b1);
      test_corners();
      test_random(350);
      drain_and_write(1'b0);
      test_random(200);
      drain_and_write(1'b1);
      test_random(150);
      req_valid <= 1'b0;
      while (expected_stencils.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("PASS tridiagonal_coarse_stencil");
      else $display("FAIL tridiagonal_coarse_stencil");
      $finish;
   end
endmodule
